[sv/bda_pkg.sv]
// Shared codes, field widths and types for the banker's deadlock-avoidance block.
`timescale 1ns / 1ps

package bda_pkg;

    // Fixed field widths of the request and result channels
    localparam int FUNC_W      = 2;
    localparam int PID_W       = 3;
    localparam int RID_W       = 2;
    localparam int VAL_W       = 8;
    localparam int STATUS_W    = 3;
    localparam int OPROC_W     = 3;
    localparam int NREQ_PORTS  = 4;

    // Configuration port
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 4;
    localparam int ACT_PROC_W  = 4;
    localparam int ACT_RES_W   = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_PROC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_RES  = 1'b1;

    // Request function codes
    localparam logic [FUNC_W-1:0] FN_SET_FREE = 2'd0;
    localparam logic [FUNC_W-1:0] FN_LOAD_ROW = 2'd1;
    localparam logic [FUNC_W-1:0] FN_REQUEST  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_LOADED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVER_NEED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVER_FREE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNSAFE    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd5;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_SCAN = 5'b00100,
        S_UNDO = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    // Flags from the row compare unit
    typedef struct packed {
        logic fits;       // need fits under base on every active resource
        logic over_need;  // some request exceeds the remaining need
        logic over_free;  // some request exceeds the base (free) units
    } t_fit_flags;

endpackage

[sv/bda_fit_unit.sv]
// Row compare unit: need against base, request against need and base, saturating release sum.
`timescale 1ns / 1ps

module bda_fit_unit #(
    parameter int NUM_RES     = 4,
    parameter int COUNT_WIDTH = 8
) (
    input  logic [NUM_RES-1:0][COUNT_WIDTH-1:0] i_claim,
    input  logic [NUM_RES-1:0][COUNT_WIDTH-1:0] i_alloc,
    input  logic [NUM_RES-1:0][COUNT_WIDTH-1:0] i_base,
    input  logic [NUM_RES-1:0][COUNT_WIDTH-1:0] i_req,
    input  logic [NUM_RES-1:0]                  i_res_mask,
    output bda_pkg::t_fit_flags                 o_flags,
    output logic [NUM_RES-1:0][COUNT_WIDTH-1:0] o_sum
);
    import bda_pkg::*;

    // All resources are handled side by side
    always_comb begin
        logic [COUNT_WIDTH-1:0] need;
        logic [COUNT_WIDTH:0]   sum;
        o_flags = '{fits: 1'b1, over_need: 1'b0, over_free: 1'b0};
        o_sum   = '0;
        for (int r = 0; r < NUM_RES; r++) begin
            need = i_claim[r] - i_alloc[r];
            if (i_req[r] > need) begin
                o_flags.over_need = 1'b1;
            end
            if (i_req[r] > i_base[r]) begin
                o_flags.over_free = 1'b1;
            end
            if (i_res_mask[r] && (need > i_base[r])) begin
                o_flags.fits = 1'b0;
            end
            // released allocation returns to the work pool, clamped at full scale
            sum = {1'b0, i_base[r]} + {1'b0, i_alloc[r]};
            o_sum[r] = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
        end
    end

endmodule

[sv/bankers_deadlock_avoidance.sv]
// Banker's algorithm deadlock-avoidance unit: load and request handling with a row-serial safety check.
// Loads and refused requests give one registered result from S_EXEC once the result register is free.
// A granted request is decoded, then scans one row per cycle and restarts at row 0 after a hit; then
// it gives one result per cycle per active row while i_out_ready is high, or one rollback result if a
// pass ends without a hit. One request in flight at a time.
// Reset (synchronous, active low) clears free, claim, alloc and out_valid; counts go to full size.
`timescale 1ns / 1ps

module bankers_deadlock_avoidance #(
    parameter int NUM_PROC    = 8,
    parameter int NUM_RES     = 4,
    parameter int COUNT_WIDTH = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [bda_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bda_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [bda_pkg::FUNC_W-1:0]       i_func,
    input  logic [bda_pkg::PID_W-1:0]        i_process_id,
    input  logic [bda_pkg::RID_W-1:0]        i_resource_id,
    input  logic [bda_pkg::VAL_W-1:0]        i_value_a,
    input  logic [bda_pkg::VAL_W-1:0]        i_value_b,
    input  logic [bda_pkg::VAL_W-1:0]        i_req_0,
    input  logic [bda_pkg::VAL_W-1:0]        i_req_1,
    input  logic [bda_pkg::VAL_W-1:0]        i_req_2,
    input  logic [bda_pkg::VAL_W-1:0]        i_req_3,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [bda_pkg::STATUS_W-1:0]     o_status,
    output logic [bda_pkg::OPROC_W-1:0]      o_order_process,
    output logic                             o_last
);
    import bda_pkg::*;

    localparam int CW  = COUNT_WIDTH;
    localparam int PW  = $clog2(NUM_PROC + 1);          // active process count
    localparam int PIW = $clog2(NUM_PROC);              // row index
    localparam int RW  = $clog2(NUM_RES + 1);           // active resource count
    localparam int RIW = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;
    localparam int PCW = (PW > PID_W) ? PW : PID_W;
    localparam int RCW = (RW > RID_W) ? RW : RID_W;

    typedef logic [NUM_RES-1:0][CW-1:0] t_vec;

    // ---------------- state ----------------
    t_state              r_state, n_state;
    logic [PW-1:0]       r_act_proc, n_act_proc;
    logic [RW-1:0]       r_act_res, n_act_res;
    t_vec                r_free, n_free;
    t_vec                r_claim [NUM_PROC];
    t_vec                n_claim [NUM_PROC];
    t_vec                r_alloc [NUM_PROC];
    t_vec                n_alloc [NUM_PROC];
    t_vec                r_work, n_work;
    logic [NUM_PROC-1:0] r_finish, n_finish;
    logic [PIW-1:0]      r_order [NUM_PROC];
    logic [PIW-1:0]      n_order [NUM_PROC];
    logic [PIW-1:0]      r_scan, n_scan;
    logic [PW-1:0]       r_found, n_found;
    logic [PIW-1:0]      r_emit, n_emit;

    // latched request
    logic [FUNC_W-1:0]   r_func, n_func;
    logic [PID_W-1:0]    r_pid, n_pid;
    logic [RID_W-1:0]    r_rid, n_rid;
    logic [CW-1:0]       r_va, n_va;
    logic [CW-1:0]       r_vb, n_vb;
    t_vec                r_req, n_req;

    // result register
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [OPROC_W-1:0]  r_oproc, n_oproc;
    logic                r_last, n_last;

    // ---------------- helpers ----------------
    logic [VAL_W-1:0]    req_port [NREQ_PORTS];
    t_vec                req_in;
    logic [NUM_RES-1:0]  res_mask;
    logic                out_free;
    logic                pid_ok, rid_ok;
    logic [PIW-1:0]      pid_idx, row_idx, last_idx;
    logic [RIW-1:0]      rid_idx;
    t_vec                unit_base, unit_sum;
    t_fit_flags          flags;
    logic                row_fits;

    assign req_port[0] = i_req_0;
    assign req_port[1] = i_req_1;
    assign req_port[2] = i_req_2;
    assign req_port[3] = i_req_3;

    // resources in use, and request units with unused kinds forced to zero
    for (genvar g = 0; g < NUM_RES; g++) begin : g_res
        assign res_mask[g] = (RW'(g) < r_act_res);
        if (g < NREQ_PORTS) begin : g_port
            assign req_in[g] = res_mask[g] ? CW'(req_port[g]) : '0;
        end else begin : g_none
            assign req_in[g] = '0;
        end
    end

    assign out_free  = !r_out_valid || i_out_ready;
    assign pid_ok    = (PCW'(r_pid) < PCW'(r_act_proc));
    assign rid_ok    = (RCW'(r_rid) < RCW'(r_act_res));
    assign pid_idx   = PIW'(r_pid);
    assign rid_idx   = RIW'(r_rid);
    assign last_idx  = PIW'(r_act_proc - PW'(1));
    assign row_idx   = (r_state == S_SCAN) ? r_scan : pid_idx;
    assign unit_base = (r_state == S_SCAN) ? r_work : r_free;

    // shared row compare unit
    bda_fit_unit #(
        .NUM_RES     (NUM_RES),
        .COUNT_WIDTH (CW)
    ) u_fit (
        .i_claim    (r_claim[row_idx]),
        .i_alloc    (r_alloc[row_idx]),
        .i_base     (unit_base),
        .i_req      (r_req),
        .i_res_mask (res_mask),
        .o_flags    (flags),
        .o_sum      (unit_sum)
    );

    assign row_fits = flags.fits && !r_finish[r_scan];

    // ---------------- sequencer ----------------
    always_comb begin
        n_state     = r_state;
        n_act_proc  = r_act_proc;
        n_act_res   = r_act_res;
        n_free      = r_free;
        n_claim     = r_claim;
        n_alloc     = r_alloc;
        n_work      = r_work;
        n_finish    = r_finish;
        n_order     = r_order;
        n_scan      = r_scan;
        n_found     = r_found;
        n_emit      = r_emit;
        n_func      = r_func;
        n_pid       = r_pid;
        n_rid       = r_rid;
        n_va        = r_va;
        n_vb        = r_vb;
        n_req       = r_req;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_oproc     = r_oproc;
        n_last      = r_last;

        // register writes, saturated to the supported range
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ACT_PROC: begin
                    if (i_cfg_wdata[ACT_PROC_W-1:0] == '0) begin
                        n_act_proc = PW'(1);
                    end else if (int'(i_cfg_wdata[ACT_PROC_W-1:0]) > NUM_PROC) begin
                        n_act_proc = PW'(NUM_PROC);
                    end else begin
                        n_act_proc = PW'(i_cfg_wdata[ACT_PROC_W-1:0]);
                    end
                end
                CFG_ACT_RES: begin
                    if (i_cfg_wdata[ACT_RES_W-1:0] == '0) begin
                        n_act_res = RW'(1);
                    end else if (int'(i_cfg_wdata[ACT_RES_W-1:0]) > NUM_RES) begin
                        n_act_res = RW'(NUM_RES);
                    end else begin
                        n_act_res = RW'(i_cfg_wdata[ACT_RES_W-1:0]);
                    end
                end
                default: begin
                end
            endcase
        end

        case (r_state)
            // take a request
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func  = i_func;
                    n_pid   = i_process_id;
                    n_rid   = i_resource_id;
                    n_va    = CW'(i_value_a);
                    n_vb    = CW'(i_value_b);
                    n_req   = req_in;
                    n_state = S_EXEC;
                end
            end

            // decode, loads and admission checks
            S_EXEC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_oproc     = '0;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                    case (r_func)
                        FN_SET_FREE: begin
                            if (rid_ok) begin
                                n_free[rid_idx] = r_va;
                                n_status        = ST_LOADED;
                            end else begin
                                n_status = ST_REJECTED;
                            end
                        end
                        FN_LOAD_ROW: begin
                            if (pid_ok && rid_ok && (r_vb <= r_va) &&
                                (r_vb <= r_free[rid_idx])) begin
                                n_claim[pid_idx][rid_idx] = r_va;
                                n_alloc[pid_idx][rid_idx] = r_vb;
                                n_free[rid_idx]           = r_free[rid_idx] - r_vb;
                                n_status                  = ST_LOADED;
                            end else begin
                                n_status = ST_REJECTED;
                            end
                        end
                        FN_REQUEST: begin
                            if (!pid_ok || flags.over_need) begin
                                n_status = ST_OVER_NEED;
                            end else if (flags.over_free) begin
                                n_status = ST_OVER_FREE;
                            end else begin
                                // tentative grant; work copy starts from the new free vector
                                n_out_valid = r_out_valid && !i_out_ready;
                                for (int r = 0; r < NUM_RES; r++) begin
                                    n_free[r]          = r_free[r] - r_req[r];
                                    n_work[r]          = r_free[r] - r_req[r];
                                    n_alloc[pid_idx][r] = r_alloc[pid_idx][r] + r_req[r];
                                end
                                n_finish = '0;
                                n_scan   = '0;
                                n_found  = '0;
                                n_state  = S_SCAN;
                            end
                        end
                        default: begin
                            n_status = ST_REJECTED;
                        end
                    endcase
                end
            end

            // one row per cycle; a hit restarts the pass at row 0
            S_SCAN: begin
                if (row_fits) begin
                    n_work            = unit_sum;
                    n_finish[r_scan]  = 1'b1;
                    n_order[PIW'(r_found)] = r_scan;
                    n_found           = r_found + PW'(1);
                    n_scan            = '0;
                    if ((r_found + PW'(1)) == r_act_proc) begin
                        n_emit  = '0;
                        n_state = S_EMIT;
                    end
                end else if (r_scan == last_idx) begin
                    n_state = S_UNDO;
                end else begin
                    n_scan = r_scan + PIW'(1);
                end
            end

            // unsafe: roll the grant back
            S_UNDO: begin
                if (out_free) begin
                    for (int r = 0; r < NUM_RES; r++) begin
                        n_free[r]           = r_free[r] + r_req[r];
                        n_alloc[pid_idx][r] = r_alloc[pid_idx][r] - r_req[r];
                    end
                    n_out_valid = 1'b1;
                    n_status    = ST_UNSAFE;
                    n_oproc     = '0;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            // safe order, one row per result
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_GRANTED;
                    n_oproc     = OPROC_W'(r_order[r_emit]);
                    n_last      = (r_emit == last_idx);
                    n_emit      = r_emit + PIW'(1);
                    if (r_emit == last_idx) begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_act_proc  <= PW'(NUM_PROC);
            r_act_res   <= RW'(NUM_RES);
            r_free      <= '0;
            r_finish    <= '0;
            r_out_valid <= 1'b0;
            for (int p = 0; p < NUM_PROC; p++) begin
                r_claim[p] <= '0;
                r_alloc[p] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_act_proc  <= n_act_proc;
            r_act_res   <= n_act_res;
            r_free      <= n_free;
            r_finish    <= n_finish;
            r_out_valid <= n_out_valid;
            r_claim     <= n_claim;
            r_alloc     <= n_alloc;
        end
    end

    // payload and scratch registers
    always_ff @(posedge i_clk) begin
        r_work   <= n_work;
        r_order  <= n_order;
        r_scan   <= n_scan;
        r_found  <= n_found;
        r_emit   <= n_emit;
        r_func   <= n_func;
        r_pid    <= n_pid;
        r_rid    <= n_rid;
        r_va     <= n_va;
        r_vb     <= n_vb;
        r_req    <= n_req;
        r_status <= n_status;
        r_oproc  <= n_oproc;
        r_last   <= n_last;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_order_process = r_oproc;
    assign o_last          = r_last;

`ifndef NO_ASSERTIONS
    // every row placed in the order is marked finished, and only those
    a_scan_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ($countones(r_finish) == int'(r_found)))
        else $error("finish marks disagree with order length");

    // a safe order covers every active row
    a_emit_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> ($countones(r_finish) == int'(r_act_proc)))
        else $error("safe order does not cover all active rows");

    // returning to idle always leaves the final result of the request pending
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) ##1 (r_state == S_IDLE) |-> (o_out_valid && o_last))
        else $error("request finished without a final result");
`endif

endmodule
